[hw/rtl/srect_pkg.sv]
// Package for the segment-rectangle intersection core: widths, stage payload
// types, configuration register indexes and small arithmetic helpers.
// No dependencies; every other file of the block imports it.
package srect_pkg;

  localparam int COORD_BITS   = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_LOW  = CFG_IDX_BITS'(0),
    REG_X_HIGH = CFG_IDX_BITS'(1),
    REG_Y_LOW  = CFG_IDX_BITS'(2),
    REG_Y_HIGH = CFG_IDX_BITS'(3)
  } cfg_reg_t;

  typedef struct packed {
    coord_t x_low;
    coord_t x_high;
    coord_t y_low;
    coord_t y_high;
  } rect_t;

  // Stage 1: coordinate differences and the early decision.
  typedef struct packed {
    diff_t abx;
    diff_t aby;
    diff_t cdx;
    diff_t cdy;
    diff_t acx;
    diff_t acy1;
    diff_t acy2;
    logic  early_done;
    logic  early_hit;
  } s1_t;

  // Stage 2: all distinct products of both diagonal tests.
  typedef struct packed {
    prod_t abx_cdy;
    prod_t aby_cdx;
    prod_t acy1_cdx;
    prod_t acx_cdy;
    prod_t acy1_abx;
    prod_t acx_aby;
    prod_t acy2_cdx;
    prod_t acy2_abx;
    logic  early_done;
    logic  early_hit;
  } s2_t;

  // Stage 3: denominators and numerators of both diagonal tests.
  typedef struct packed {
    sum_t den1;
    sum_t nl1;
    sum_t nm1;
    sum_t den2;
    sum_t nl2;
    sum_t nm2;
    logic early_done;
    logic early_hit;
  } s3_t;

  // Sign-extend a coordinate by one bit so that a difference cannot wrap.
  function automatic diff_t sx(input coord_t a);
    return {a[COORD_BITS-1], a};
  endfunction

  // Sign-extend a product by one bit so that a sum cannot wrap.
  function automatic sum_t px(input prod_t a);
    return {a[PROD_W-1], a};
  endfunction

  // Exact test of num/den within [0,1]; a zero denominator counts as a hit.
  function automatic logic in_unit(input sum_t num, input sum_t den);
    logic r;
    if (den == '0) begin
      r = 1'b1;
    end else if (den > 0) begin
      r = (num >= 0) && (num <= den);
    end else begin
      r = (num <= 0) && (num >= den);
    end
    return r;
  endfunction

endpackage

[hw/rtl/srect_in_if.sv]
// Input channel interface: one segment item with a valid/ready handshake.
// Depends on srect_pkg for the coordinate type.
interface srect_in_if import srect_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

[hw/rtl/srect_out_if.sv]
// Result channel interface: one hit flag per item with a valid/ready handshake.
// Depends on srect_pkg through its import, but carries no package types.
interface srect_out_if import srect_pkg::*; ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

[hw/rtl/srect_front.sv]
// First pipeline stage: edge rejection, endpoint inclusion and the
// coordinate differences of both diagonal tests. Depends on srect_pkg.
module srect_front import srect_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  rect_t  rect,
  input  coord_t x1,
  input  coord_t y1,
  input  coord_t x2,
  input  coord_t y2,
  output s1_t    s1_r
);

  s1_t  s1_nxt;
  logic rejected;
  logic inside1;
  logic inside2;

  // Both endpoints beyond the same edge is an immediate miss.
  always_comb begin
    rejected = (x1 < rect.x_low  && x2 < rect.x_low)  ||
               (x1 > rect.x_high && x2 > rect.x_high) ||
               (y1 < rect.y_low  && y2 < rect.y_low)  ||
               (y1 > rect.y_high && y2 > rect.y_high);
    inside1  = x1 >= rect.x_low && x1 <= rect.x_high &&
               y1 >= rect.y_low && y1 <= rect.y_high;
    inside2  = x2 >= rect.x_low && x2 <= rect.x_high &&
               y2 >= rect.y_low && y2 <= rect.y_high;
  end

  // Differences for the segment and the two diagonals.
  always_comb begin
    s1_nxt.abx        = sx(x2) - sx(x1);
    s1_nxt.aby        = sx(y2) - sx(y1);
    s1_nxt.cdx        = sx(rect.x_high) - sx(rect.x_low);
    s1_nxt.cdy        = sx(rect.y_high) - sx(rect.y_low);
    s1_nxt.acx        = sx(x1) - sx(rect.x_low);
    s1_nxt.acy1       = sx(y1) - sx(rect.y_low);
    s1_nxt.acy2       = sx(y1) - sx(rect.y_high);
    s1_nxt.early_done = rejected || inside1 || inside2;
    s1_nxt.early_hit  = !rejected && (inside1 || inside2);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

[hw/rtl/srect_mul.sv]
// Second pipeline stage: the eight distinct cross-product terms, one
// 17 by 17 bit signed multiplier each, registered. Depends on srect_pkg.
module srect_mul import srect_pkg::*; (
  input  logic clk,
  input  logic load,
  input  s1_t  s1,
  output s2_t  s2_r
);

  s2_t s2_nxt;

  function automatic prod_t mul(input diff_t a, input diff_t b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

  // The second diagonal shares most terms with the first.
  always_comb begin
    s2_nxt.abx_cdy    = mul(s1.abx,  s1.cdy);
    s2_nxt.aby_cdx    = mul(s1.aby,  s1.cdx);
    s2_nxt.acy1_cdx   = mul(s1.acy1, s1.cdx);
    s2_nxt.acx_cdy    = mul(s1.acx,  s1.cdy);
    s2_nxt.acy1_abx   = mul(s1.acy1, s1.abx);
    s2_nxt.acx_aby    = mul(s1.acx,  s1.aby);
    s2_nxt.acy2_cdx   = mul(s1.acy2, s1.cdx);
    s2_nxt.acy2_abx   = mul(s1.acy2, s1.abx);
    s2_nxt.early_done = s1.early_done;
    s2_nxt.early_hit  = s1.early_hit;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

[hw/rtl/srect_decide.sv]
// Third pipeline stage: denominators and numerators of both diagonal tests,
// registered, then the exact range checks that give the hit flag.
// Depends on srect_pkg.
module srect_decide import srect_pkg::*; (
  input  logic clk,
  input  logic load,
  input  s2_t  s2,
  output s3_t  s3_r,
  output logic hit
);

  s3_t  s3_nxt;
  logic cross1;
  logic cross2;

  // The second diagonal runs the other way in y, which flips the sign of
  // every term that carries its y extent.
  always_comb begin
    s3_nxt.den1       = px(s2.abx_cdy)  - px(s2.aby_cdx);
    s3_nxt.nl1        = px(s2.acy1_cdx) - px(s2.acx_cdy);
    s3_nxt.nm1        = px(s2.acy1_abx) - px(s2.acx_aby);
    s3_nxt.den2       = -px(s2.abx_cdy) - px(s2.aby_cdx);
    s3_nxt.nl2        = px(s2.acy2_cdx) + px(s2.acx_cdy);
    s3_nxt.nm2        = px(s2.acy2_abx) - px(s2.acx_aby);
    s3_nxt.early_done = s2.early_done;
    s3_nxt.early_hit  = s2.early_hit;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s3_r <= s3_nxt;
    end
  end

  // Final decision from the registered sums.
  always_comb begin
    cross1 = in_unit(s3_r.nl1, s3_r.den1) && in_unit(s3_r.nm1, s3_r.den1);
    cross2 = in_unit(s3_r.nl2, s3_r.den2) && in_unit(s3_r.nm2, s3_r.den2);
    hit    = s3_r.early_done ? s3_r.early_hit : (cross1 || cross2);
  end

endmodule

[hw/rtl/segment_rect_intersect_core.sv]
// Segment against rectangle intersection test.
// The rectangle is held in four signed configuration registers written
// through cfg_we, cfg_index and cfg_wdata: index 0 left edge, 1 right edge,
// 2 bottom edge, 3 top edge, all inclusive; writes to other indexes are
// ignored. The user must write configuration only while no item is in
// flight; the block does not enforce it. Each item on in_seg carries one
// segment (start_x, start_y, end_x, end_y); for each one exactly one item
// leaves on out_res with hit set when the segment touches the rectangle.
// The block is a four-register pipeline: differences, products, sums, and
// the output register that holds the decision, passed in that order.
// Throughput is one item per cycle while out_res.ready stays high, set by
// the fully pipelined multiplier stage.
// When the receiver holds out_res.ready low, the stages fill up behind the
// output register and in_seg.ready falls only once all four are occupied;
// nothing is lost or repeated. Reset (rst_n low at a clock edge) empties
// the pipeline and clears all four rectangle registers to zero.
// Depends on srect_pkg, srect_in_if, srect_out_if, srect_front, srect_mul
// and srect_decide.
module segment_rect_intersect_core import srect_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  srect_in_if.sink                in_seg,
  srect_out_if.source             out_res,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_wdata
);

  rect_t rect_r;
  logic  v1_r, v2_r, v3_r, out_valid_r;
  logic  out_hit_r;
  logic  en1, en2, en3, en_out;
  s1_t   s1_r;
  s2_t   s2_r;
  s3_t   s3_r;
  logic  hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_LOW:  rect_r.x_low  <= coord_t'(cfg_wdata);
        REG_X_HIGH: rect_r.x_high <= coord_t'(cfg_wdata);
        REG_Y_LOW:  rect_r.y_low  <= coord_t'(cfg_wdata);
        REG_Y_HIGH: rect_r.y_high <= coord_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Each stage advances when it is empty or the next one advances.
  assign en_out       = !out_valid_r || out_res.ready;
  assign en3          = !v3_r || en_out;
  assign en2          = !v2_r || en3;
  assign en1          = !v1_r || en2;
  assign in_seg.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_seg.valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  srect_front u_front (
    .clk  (clk),
    .load (en1 && in_seg.valid),
    .rect (rect_r),
    .x1   (in_seg.start_x),
    .y1   (in_seg.start_y),
    .x2   (in_seg.end_x),
    .y2   (in_seg.end_y),
    .s1_r (s1_r)
  );

  srect_mul u_mul (
    .clk  (clk),
    .load (en2 && v1_r),
    .s1   (s1_r),
    .s2_r (s2_r)
  );

  srect_decide u_decide (
    .clk  (clk),
    .load (en3 && v2_r),
    .s2   (s2_r),
    .s3_r (s3_r),
    .hit  (hit)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (en_out && v3_r) begin
      out_hit_r <= hit;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.hit   = out_hit_r;

  // A full pipeline with a stalled receiver must refuse new items.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && out_valid_r && !out_res.ready) |-> !in_seg.ready)
    else $error("input accepted while the pipeline is full and stalled");

  // A held middle stage keeps its item.
  a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en3) |=> (v2_r && $stable(s2_r)))
    else $error("stage two item changed while held");

  // An early decision reaches the output unchanged.
  a_early: assert property (@(posedge clk) disable iff (!rst_n)
    (en_out && v3_r && s3_r.early_done) |=> (out_res.hit == $past(s3_r.early_hit)))
    else $error("early decision not carried to the output");

  // An item leaving the last stage always lands in the output register.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en_out && v3_r) |=> out_valid_r)
    else $error("item lost between the last stage and the output");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for segment_rect_intersect_core: segments against a configured rectangle.
// Depends on srect_pkg, srect_in_if and srect_out_if from the RTL. A local hit predictor is
// compared with each result. Directed corner cases run first, then random rectangles and segments.
module tb_top;
  import srect_pkg::*;

  localparam int     PIPE_LATENCY = 4;
  localparam int     IDLE_PERCENT = 32;
  localparam int     CFG_IDX_TOP  = (1 << CFG_IDX_BITS) - 1;
  localparam coord_t COORD_MAX    = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN    = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    logic   hit;
  } hit_record_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]   cfg_wdata;

  srect_in_if  in_seg ();
  srect_out_if out_res ();

  segment_rect_intersect_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_seg    (in_seg),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the rectangle, as it stands in the block.
  coord_t rect_x_lo = '0;
  coord_t rect_x_hi = '0;
  coord_t rect_y_lo = '0;
  coord_t rect_y_hi = '0;

  hit_record_t hit_expect_q[$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

  // Receiver: ready is lowered at random while idling is enabled.
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_res.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Parameter num/den within [0,1], compared exactly; den is nonzero.
  function automatic logic within_unit(longint num, longint den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  // Segment a-b against diagonal c-d; a zero cross product counts as a crossing.
  function automatic logic crosses_diagonal(longint ax, longint ay, longint bx, longint by,
                                            longint cx, longint cy, longint dx, longint dy);
    longint abx, aby, cdx, cdy, acx, acy, den, nl, nm;
    abx = bx - ax;
    aby = by - ay;
    cdx = dx - cx;
    cdy = dy - cy;
    acx = ax - cx;
    acy = ay - cy;
    den = abx * cdy - aby * cdx;
    if (den == 0) begin
      return 1'b1;
    end
    nl = acy * cdx - acx * cdy;
    nm = acy * abx - acx * aby;
    return within_unit(nl, den) && within_unit(nm, den);
  endfunction

  // Expected hit flag for one segment against the current rectangle.
  function automatic logic predict_hit(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint x1, y1, x2, y2, xl, xh, yl, yh;
    logic   start_in, end_in;
    x1 = sx;
    y1 = sy;
    x2 = ex;
    y2 = ey;
    xl = rect_x_lo;
    xh = rect_x_hi;
    yl = rect_y_lo;
    yh = rect_y_hi;
    // Early rejection when both endpoints lie beyond the same edge.
    if ((x1 < xl && x2 < xl) || (x1 > xh && x2 > xh) ||
        (y1 < yl && y2 < yl) || (y1 > yh && y2 > yh)) begin
      return 1'b0;
    end
    start_in = (x1 >= xl) && (x1 <= xh) && (y1 >= yl) && (y1 <= yh);
    end_in   = (x2 >= xl) && (x2 <= xh) && (y2 >= yl) && (y2 <= yh);
    if (start_in || end_in) begin
      return 1'b1;
    end
    return crosses_diagonal(x1, y1, x2, y2, xl, yl, xh, yh) ||
           crosses_diagonal(x1, y1, x2, y2, xl, yh, xh, yl);
  endfunction

  // Result checker: each accepted item is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    hit_record_t rec;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (hit_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, out_res.hit);
      end else begin
        rec = hit_expect_q.pop_front();
        if (out_res.hit !== rec.hit) begin
          mismatch_count++;
          $display("%0t: hit mismatch for (%0d,%0d)-(%0d,%0d), expected %0b, actual %0b",
                   $time, rec.x1, rec.y1, rec.x2, rec.y2, rec.hit, out_res.hit);
        end
      end
    end
  end

  // Send one segment item and record its expected hit once it is accepted.
  task automatic send_segment(input coord_t x1, input coord_t y1,
                              input coord_t x2, input coord_t y2);
    @(negedge clk);
    while (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      in_seg.valid <= 1'b0;
      @(negedge clk);
    end
    in_seg.valid   <= 1'b1;
    in_seg.start_x <= x1;
    in_seg.start_y <= y1;
    in_seg.end_x   <= x2;
    in_seg.end_y   <= y2;
    do begin
      @(posedge clk);
    end while (!in_seg.ready);
    hit_expect_q.push_back('{x1, y1, x2, y2, predict_hit(x1, y1, x2, y2)});
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_seg.valid <= 1'b0;
    while (hit_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write one register; indexes above the top edge are ignored by the block.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_X_LOW:  rect_x_lo = val;
      REG_X_HIGH: rect_x_hi = val;
      REG_Y_LOW:  rect_y_lo = val;
      REG_Y_HIGH: rect_y_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_rect(input coord_t xl, input coord_t xh, input coord_t yl, input coord_t yh);
    wait_idle();
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_HIGH, yh);
  endtask

  // A coordinate around the span lo..hi, with a margin on both sides.
  function automatic coord_t near_coord(coord_t lo, coord_t hi);
    longint a, b, margin, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    margin = (b - a) / 2 + 4;
    v = a - margin + longint'($urandom_range(0, int'(b - a + 2 * margin)));
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end
    if (v < COORD_MIN) begin
      v = COORD_MIN;
    end
    return coord_t'(v);
  endfunction

  function automatic coord_t corner_coord(coord_t lo, coord_t hi);
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return near_coord(lo, hi);
    endcase
  endfunction

  // One random segment: mostly close to the rectangle, the rest wide, extreme, degenerate or parallel to a diagonal.
  task automatic send_random_segment();
    coord_t x1, y1, x2, y2;
    int     pick;
    longint dx, dy;
    pick = $urandom_range(0, 99);
    x1 = near_coord(rect_x_lo, rect_x_hi);
    y1 = near_coord(rect_y_lo, rect_y_hi);
    x2 = near_coord(rect_x_lo, rect_x_hi);
    y2 = near_coord(rect_y_lo, rect_y_hi);
    if (pick >= 55 && pick < 75) begin
      x1 = coord_t'($urandom);
      y1 = coord_t'($urandom);
      x2 = coord_t'($urandom);
      y2 = coord_t'($urandom);
    end else if (pick >= 75 && pick < 85) begin
      x1 = corner_coord(rect_x_lo, rect_x_hi);
      y1 = corner_coord(rect_y_lo, rect_y_hi);
      x2 = corner_coord(rect_x_lo, rect_x_hi);
      y2 = corner_coord(rect_y_lo, rect_y_hi);
    end else if (pick >= 85 && pick < 92) begin
      x2 = x1;
      y2 = y1;
    end else if (pick >= 92) begin
      // Parallel to one of the diagonals; wrapping is allowed.
      dx = longint'(rect_x_hi) - longint'(rect_x_lo);
      dy = longint'(rect_y_hi) - longint'(rect_y_lo);
      if ($urandom_range(0, 1)) begin
        dy = -dy;
      end
      if ($urandom_range(0, 1)) begin
        dx = -dx;
        dy = -dy;
      end
      x2 = coord_t'(longint'(x1) + dx);
      y2 = coord_t'(longint'(y1) + dy);
    end
    send_segment(x1, y1, x2, y2);
  endtask

  // The rectangle after reset is the single point at the origin.
  task automatic test_reset_rect();
    send_segment('0, '0, '0, '0);
    send_segment(-16'sd5, '0, 16'sd5, '0);
    send_segment(16'sd1, 16'sd1, 16'sd2, 16'sd2);
    send_segment(-16'sd3, -16'sd3, 16'sd3, 16'sd3);
  endtask

  // Each stage of the decision, inclusive edges, degenerate and extreme rectangles.
  task automatic test_edge_cases();
    set_rect(-16'sd100, 16'sd100, -16'sd50, 16'sd50);
    send_segment(-16'sd200, '0, -16'sd101, 16'sd10);
    send_segment(16'sd101, -16'sd10, 16'sd300, 16'sd40);
    send_segment('0, -16'sd51, 16'sd50, -16'sd300);
    send_segment(-16'sd20, 16'sd51, 16'sd20, 16'sd60);
    send_segment(-16'sd100, -16'sd50, -16'sd400, -16'sd400);
    send_segment(16'sd500, '0, 16'sd100, 16'sd50);
    send_segment(-16'sd300, '0, 16'sd300, '0);
    send_segment(-16'sd300, -16'sd300, 16'sd300, 16'sd300);
    send_segment(16'sd90, 16'sd70, 16'sd130, 16'sd40);
    send_segment(16'sd60, -16'sd80, 16'sd160, -16'sd30);
    send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    // A write above the last register index must leave the rectangle alone.
    wait_idle();
    write_reg(CFG_IDX_BITS'($urandom_range(int'(REG_Y_HIGH) + 1, CFG_IDX_TOP)), COORD_MIN);
    send_segment(16'sd100, 16'sd50, 16'sd100, 16'sd50);
    // Full-range rectangle.
    set_rect(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    send_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    // Inverted rectangle at the extremes; edges are not swapped.
    set_rect(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    send_segment('0, '0, '0, '0);
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    // Zero-size rectangle: both diagonals have zero length.
    set_rect(16'sd10, 16'sd10, -16'sd10, -16'sd10);
    send_segment(16'sd10, -16'sd10, 16'sd10, -16'sd10);
    send_segment('0, -16'sd20, 16'sd20, '0);
  endtask

  // Random rectangles of several shapes, each followed by a batch of random segments.
  task automatic test_random_rects(input int phases, input int per_phase);
    coord_t xl, xh, yl, yh, cx, cy;
    int     shape;
    for (int p = 0; p < phases; p++) begin
      shape = (p < 6) ? p : $urandom_range(0, 5);
      cx = coord_t'($urandom_range(0, 400)) - 16'sd200;
      cy = coord_t'($urandom_range(0, 400)) - 16'sd200;
      case (shape)
        0: begin
          xl = cx;
          xh = cx + coord_t'($urandom_range(0, 200));
          yl = cy;
          yh = cy + coord_t'($urandom_range(0, 200));
        end
        1: begin
          xl = coord_t'($urandom_range(0, 60000)) - 16'sd30000;
          xh = xl + coord_t'($urandom_range(0, 2000));
          yl = coord_t'($urandom_range(0, 60000)) - 16'sd30000;
          yh = yl + coord_t'($urandom_range(0, 2000));
        end
        2: begin
          xl = coord_t'($urandom);
          xh = coord_t'($urandom);
          yl = coord_t'($urandom);
          yh = coord_t'($urandom);
        end
        3: begin
          xl = COORD_MIN;
          xh = COORD_MAX;
          yl = cy;
          yh = COORD_MAX;
        end
        4: begin
          xl = cx + 16'sd50;
          xh = cx;
          yl = COORD_MAX;
          yh = COORD_MIN;
        end
        default: begin
          xl = cx;
          xh = cx;
          yl = cy;
          yh = cy + coord_t'($urandom_range(0, 1));
        end
      endcase
      set_rect(xl, xh, yl, yh);
      repeat (per_phase) send_random_segment();
    end
  endtask

  // Back-to-back items with the receiver always ready.
  task automatic test_full_rate(input int count);
    set_rect(-16'sd1000, 16'sd1000, -16'sd600, 16'sd800);
    idle_on = 1'b0;
    repeat (count) send_random_segment();
    wait_idle();
    idle_on = 1'b1;
  endtask

  // The sender holds off until the pipeline has emptied, then resumes.
  task automatic test_drain_pause(input int count);
    repeat (count) send_random_segment();
    wait_idle();
    repeat (count) send_random_segment();
  endtask

  // Reset, the tests in turn, then the final verdict.
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_seg.valid   = 1'b0;
    in_seg.start_x = '0;
    in_seg.start_y = '0;
    in_seg.end_x   = '0;
    in_seg.end_y   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_rect();
    test_edge_cases();
    test_random_rects(12, 80);
    test_full_rate(150);
    test_drain_pause(30);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[segment_rect_intersect_core.f]
hw/rtl/srect_pkg.sv
hw/rtl/srect_in_if.sv
hw/rtl/srect_out_if.sv
hw/rtl/srect_front.sv
hw/rtl/srect_mul.sv
hw/rtl/srect_decide.sv
hw/rtl/segment_rect_intersect_core.sv
tb/tb_top.sv
